// ===== hdl/lls_pkg.sv =====
package lls_pkg;

    localparam int TABLE_ENTRIES = 64;
    localparam int KEY_BITS      = 32;
    localparam int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

    typedef logic [KEY_BITS-1:0] t_key;
    typedef logic [IDX_W-1:0]    t_idx;
    typedef logic [7:0]          t_load;

    typedef enum logic [2:0] {
        OP_ADD      = 3'd0,
        OP_DELETE   = 3'd1,
        OP_SET      = 3'd2,
        OP_FIND     = 3'd3,
        OP_FIND_MIN = 3'd4
    } t_op;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2,
        ST_PRESENT   = 2'd3
    } t_status;

    typedef struct packed {
        logic  act;
        t_key  key;
        logic  hit;
        t_idx  hit_idx;
        t_load hit_load;
        logic  free;
        t_idx  free_idx;
        logic  min_found;
        t_key  min_key;
        t_load min_load;
    } t_tok;

    typedef struct packed {
        logic  en;
        t_op   op;
        t_idx  idx;
        t_key  key;
        t_load load;
    } t_wr;

endpackage

// ===== hdl/lls_cell.sv =====
module lls_cell (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  lls_pkg::t_idx i_index,
    input  lls_pkg::t_tok i_tok,
    input  lls_pkg::t_wr  i_wr,
    output lls_pkg::t_tok o_tok
);

    logic           r_valid;
    lls_pkg::t_key  r_key;
    lls_pkg::t_load r_load;
    lls_pkg::t_tok  r_tok;
    lls_pkg::t_tok  n_tok;
    logic           sel;

    assign sel = i_wr.en && (i_wr.idx == i_index);

    always_comb begin
        n_tok = i_tok;
        if (!i_tok.hit && r_valid && (r_key == i_tok.key)) begin
            n_tok.hit      = 1'b1;
            n_tok.hit_idx  = i_index;
            n_tok.hit_load = r_load;
        end
        if (!i_tok.free && !r_valid) begin
            n_tok.free     = 1'b1;
            n_tok.free_idx = i_index;
        end
        if (r_valid && (!i_tok.min_found || (r_load < i_tok.min_load) ||
                        ((r_load == i_tok.min_load) && (r_key < i_tok.min_key)))) begin
            n_tok.min_found = 1'b1;
            n_tok.min_key   = r_key;
            n_tok.min_load  = r_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= 1'b0;
            r_tok.act <= 1'b0;
        end else begin
            r_tok <= n_tok;
            if (sel) begin
                case (i_wr.op)
                    lls_pkg::OP_ADD: begin
                        r_valid <= 1'b1;
                        r_key   <= i_wr.key;
                        r_load  <= '0;
                    end
                    lls_pkg::OP_DELETE: r_valid <= 1'b0;
                    lls_pkg::OP_SET:    r_load  <= i_wr.load;
                    default: ;
                endcase
            end
        end
    end

    assign o_tok = r_tok;

endmodule

// ===== hdl/least_loaded_session_table.sv =====
// One transaction at a time: input is taken only in the idle state. The search
// token walks the cell chain one entry per cycle; its outcome is registered, then
// the update is applied when the result enters the output register.
// A pending result waits in the output register while the next item is taken.
// Reset (synchronous, active low) clears all entries at once; no sweep.
module least_loaded_session_table (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [2:0]  i_opcode,
    input  logic [31:0] i_session_key,
    input  logic [7:0]  i_load_value,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_found,
    output logic [31:0] o_result_key,
    output logic [7:0]  o_result_load,
    output logic [1:0]  o_status
);

    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_WAIT} t_state;

    localparam int N = lls_pkg::TABLE_ENTRIES;

    t_state             r_state;
    lls_pkg::t_op       r_op;
    lls_pkg::t_load     r_load_in;
    logic               r_res_found;
    lls_pkg::t_key      r_res_key;
    lls_pkg::t_load     r_res_load;
    lls_pkg::t_status   r_res_status;
    lls_pkg::t_wr       r_wr;
    logic               r_o_valid;
    logic               r_found;
    lls_pkg::t_key      r_key_out;
    lls_pkg::t_load     r_load_out;
    lls_pkg::t_status   r_status;

    lls_pkg::t_tok      tok [0:N];
    lls_pkg::t_wr       wr;
    lls_pkg::t_tok      tok_end;
    logic               accept;
    logic               out_free;

    logic               res_found;
    lls_pkg::t_key      res_key;
    lls_pkg::t_load     res_load;
    lls_pkg::t_status   res_status;
    lls_pkg::t_wr       res_wr;

    assign accept   = i_valid && (r_state == S_IDLE);
    assign o_stall  = (r_state != S_IDLE);
    assign out_free = !r_o_valid || !i_stall;
    assign tok_end  = tok[N];

    always_comb begin
        tok[0]     = '0;
        tok[0].act = accept;
        tok[0].key = lls_pkg::t_key'(i_session_key);
    end

    always_comb begin
        wr    = r_wr;
        wr.en = r_wr.en && (r_state == S_WAIT) && out_free;
    end

    for (genvar g = 0; g < N; g++) begin : g_cell
        lls_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_index (lls_pkg::t_idx'(g)),
            .i_tok   (tok[g]),
            .i_wr    (wr),
            .o_tok   (tok[g+1])
        );
    end

    always_comb begin
        res_found  = 1'b0;
        res_key    = '0;
        res_load   = '0;
        res_status = lls_pkg::ST_NOT_FOUND;
        res_wr     = '0;
        res_wr.op  = r_op;
        res_wr.key = tok_end.key;
        res_wr.load = r_load_in;
        case (r_op)
            lls_pkg::OP_ADD: begin
                if (tok_end.hit) begin
                    res_status = lls_pkg::ST_PRESENT;
                end else if (!tok_end.free) begin
                    res_status = lls_pkg::ST_FULL;
                end else begin
                    res_found  = 1'b1;
                    res_status = lls_pkg::ST_OK;
                    res_wr.en  = 1'b1;
                    res_wr.idx = tok_end.free_idx;
                end
            end
            lls_pkg::OP_DELETE, lls_pkg::OP_SET: begin
                if (tok_end.hit) begin
                    res_found  = 1'b1;
                    res_status = lls_pkg::ST_OK;
                    res_wr.en  = 1'b1;
                    res_wr.idx = tok_end.hit_idx;
                end
            end
            lls_pkg::OP_FIND: begin
                if (tok_end.hit) begin
                    res_found  = 1'b1;
                    res_key    = tok_end.key;
                    res_load   = tok_end.hit_load;
                    res_status = lls_pkg::ST_OK;
                end
            end
            lls_pkg::OP_FIND_MIN: begin
                if (tok_end.min_found) begin
                    res_found  = 1'b1;
                    res_key    = tok_end.min_key;
                    res_load   = tok_end.min_load;
                    res_status = lls_pkg::ST_OK;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_o_valid <= 1'b0;
            r_wr.en   <= 1'b0;
        end else begin
            if (r_o_valid && !i_stall && (r_state != S_WAIT)) begin
                r_o_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_op      <= lls_pkg::t_op'(i_opcode);
                        r_load_in <= i_load_value;
                        r_state   <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (tok_end.act) begin
                        r_res_found  <= res_found;
                        r_res_key    <= res_key;
                        r_res_load   <= res_load;
                        r_res_status <= res_status;
                        r_wr         <= res_wr;
                        r_state      <= S_WAIT;
                    end
                end
                S_WAIT: begin
                    if (out_free) begin
                        r_o_valid  <= 1'b1;
                        r_found    <= r_res_found;
                        r_key_out  <= r_res_key;
                        r_load_out <= r_res_load;
                        r_status   <= r_res_status;
                        r_wr.en    <= 1'b0;
                        r_state    <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid       = r_o_valid;
    assign o_found       = r_found;
    assign o_result_key  = 32'(r_key_out);
    assign o_result_load = r_load_out;
    assign o_status      = r_status;

endmodule

// ===== hdl/lls_checker.sv =====
module lls_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic        o_found,
    input logic [31:0] o_result_key,
    input logic [7:0]  o_result_load,
    input logic [1:0]  o_status
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_found) && $stable(o_result_key)
            && $stable(o_result_load) && $stable(o_status))
        else $error("stalled result changed");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("input taken while a transaction is in flight");

    a_no_early_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> !$rose(o_valid))
        else $error("result appeared right after input transaction");

    a_found_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_found == (o_status == lls_pkg::ST_OK)))
        else $error("found disagrees with status");

    a_zero_on_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_found |-> (o_result_key == 32'd0) && (o_result_load == 8'd0))
        else $error("returned fields not zero on failed transaction");

endmodule

bind least_loaded_session_table lls_checker u_lls_checker (.*);

// ===== tb/sv/least_loaded_session_table_test.sv =====
module least_loaded_session_table_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0] OP_RSVD_FIRST = 3'd5;
    localparam logic [2:0] OP_RSVD_LAST  = 3'd7;
    localparam int         KEY_POOL_SIZE = 80;
    localparam int         STALL_LIMIT   = 3000;
    localparam int         TAIL_CYCLES   = lls_pkg::TABLE_ENTRIES + 10;
    localparam int         HOLD_CYCLES   = 400;

    typedef struct packed {
        logic             found;
        lls_pkg::t_key    key;
        lls_pkg::t_load   load;
        lls_pkg::t_status status;
    } t_session_result;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_valid       = 1'b0;
    logic        o_stall;
    logic [2:0]  i_opcode      = 3'd0;
    logic [31:0] i_session_key = 32'd0;
    logic [7:0]  i_load_value  = 8'd0;
    logic        o_valid;
    logic        i_stall       = 1'b0;
    logic        o_found;
    logic [31:0] o_result_key;
    logic [7:0]  o_result_load;
    logic [1:0]  o_status;

    logic           tbl_valid [lls_pkg::TABLE_ENTRIES];
    lls_pkg::t_key  tbl_key   [lls_pkg::TABLE_ENTRIES];
    lls_pkg::t_load tbl_load  [lls_pkg::TABLE_ENTRIES];
    lls_pkg::t_key  key_pool  [KEY_POOL_SIZE];

    t_session_result pending_results [$];

    int errors        = 0;
    int n_sent        = 0;
    int n_checked     = 0;
    int n_full_adds   = 0;
    int n_dup_adds    = 0;
    int n_min_hits    = 0;
    int tx_idle_pct   = 18;
    int rx_idle_pct   = 18;
    int hold_seq      = 0;
    int hold_seen     = 0;
    int hold_left     = 0;
    int no_progress   = 0;

    least_loaded_session_table u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_opcode      (i_opcode),
        .i_session_key (i_session_key),
        .i_load_value  (i_load_value),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_found       (o_found),
        .o_result_key  (o_result_key),
        .o_result_load (o_result_load),
        .o_status      (o_status)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 0;
    end

    function automatic int lookup_slot(input lls_pkg::t_key key);
        for (int i = 0; i < lls_pkg::TABLE_ENTRIES; i++) begin
            if (tbl_valid[i] && tbl_key[i] == key) begin
                return i;
            end
        end
        return -1;
    endfunction

    function automatic t_session_result predict_result(input logic [2:0] op,
                                                       input lls_pkg::t_key key,
                                                       input lls_pkg::t_load ld);
        t_session_result res;
        int hit;
        int slot;
        res = '{found: 1'b0, key: '0, load: '0, status: lls_pkg::ST_NOT_FOUND};
        hit = lookup_slot(key);
        case (op)
            lls_pkg::OP_ADD: begin
                if (hit >= 0) begin
                    res.status = lls_pkg::ST_PRESENT;
                    n_dup_adds++;
                end else begin
                    slot = -1;
                    for (int i = 0; i < lls_pkg::TABLE_ENTRIES && slot < 0; i++) begin
                        if (!tbl_valid[i]) begin
                            slot = i;
                        end
                    end
                    if (slot < 0) begin
                        res.status = lls_pkg::ST_FULL;
                        n_full_adds++;
                    end else begin
                        tbl_key[slot]   = key;
                        tbl_load[slot]  = '0;
                        tbl_valid[slot] = 1'b1;
                        res.found       = 1'b1;
                        res.status      = lls_pkg::ST_OK;
                    end
                end
            end
            lls_pkg::OP_DELETE: begin
                if (hit >= 0) begin
                    tbl_valid[hit] = 1'b0;
                    res.found      = 1'b1;
                    res.status     = lls_pkg::ST_OK;
                end
            end
            lls_pkg::OP_SET: begin
                if (hit >= 0) begin
                    tbl_load[hit] = ld;
                    res.found     = 1'b1;
                    res.status    = lls_pkg::ST_OK;
                end
            end
            lls_pkg::OP_FIND: begin
                if (hit >= 0) begin
                    res = '{found: 1'b1, key: tbl_key[hit], load: tbl_load[hit],
                            status: lls_pkg::ST_OK};
                end
            end
            lls_pkg::OP_FIND_MIN: begin
                slot = -1;
                for (int i = 0; i < lls_pkg::TABLE_ENTRIES; i++) begin
                    if (tbl_valid[i] && (slot < 0 || tbl_load[i] < tbl_load[slot] ||
                        (tbl_load[i] == tbl_load[slot] && tbl_key[i] < tbl_key[slot]))) begin
                        slot = i;
                    end
                end
                if (slot >= 0) begin
                    res = '{found: 1'b1, key: tbl_key[slot], load: tbl_load[slot],
                            status: lls_pkg::ST_OK};
                    n_min_hits++;
                end
            end
            default: begin
            end
        endcase
        return res;
    endfunction

    task automatic send_request(input logic [2:0] op, input lls_pkg::t_key key,
                                input lls_pkg::t_load ld);
        int gap;
        t_session_result want;
        gap = 0;
        if ($urandom_range(99) < tx_idle_pct) begin
            gap = $urandom_range(90, 1);
        end
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_opcode      <= op;
        i_session_key <= key;
        i_load_value  <= ld;
        @(posedge i_clk);
        while (o_stall) begin
            @(posedge i_clk);
        end
        want = predict_result(op, key, ld);
        pending_results.insert(pending_results.size(), want);
        n_sent++;
    endtask

    task automatic send_random_request();
        int    pick;
        logic [2:0] op;
        lls_pkg::t_key  key;
        lls_pkg::t_load ld;
        pick = $urandom_range(99);
        if (pick < 35) begin
            op = lls_pkg::OP_ADD;
        end else if (pick < 52) begin
            op = lls_pkg::OP_DELETE;
        end else if (pick < 72) begin
            op = lls_pkg::OP_SET;
        end else if (pick < 85) begin
            op = lls_pkg::OP_FIND;
        end else if (pick < 95) begin
            op = lls_pkg::OP_FIND_MIN;
        end else begin
            op = 3'($urandom_range(OP_RSVD_LAST, OP_RSVD_FIRST));
        end
        if ($urandom_range(9) == 0) begin
            key = $urandom;
        end else begin
            key = key_pool[$urandom_range(KEY_POOL_SIZE - 1)];
        end
        case ($urandom_range(9))
            0:       ld = 8'h00;
            1:       ld = 8'hFF;
            2, 3:    ld = 8'($urandom_range(3));
            default: ld = 8'($urandom_range(255));
        endcase
        send_request(op, key, ld);
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        while (pending_results.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic test_directed_ops();
        send_request(lls_pkg::OP_FIND_MIN, 32'h0, 8'h00);
        send_request(lls_pkg::OP_DELETE, 32'h0, 8'h00);
        send_request(lls_pkg::OP_SET, 32'hFFFF_FFFF, 8'hFF);
        send_request(lls_pkg::OP_FIND, 32'h0, 8'h00);
        for (logic [3:0] op = 4'(OP_RSVD_FIRST); op <= 4'(OP_RSVD_LAST); op++) begin
            send_request(op[2:0], 32'hFFFF_FFFF, 8'hFF);
        end
        send_request(lls_pkg::OP_ADD, 32'h0, 8'hAA);
        send_request(lls_pkg::OP_ADD, 32'hFFFF_FFFF, 8'hFF);
        send_request(lls_pkg::OP_ADD, 32'h0, 8'h55);
        send_request(lls_pkg::OP_FIND, 32'h0, 8'hFF);
        send_request(lls_pkg::OP_SET, 32'hFFFF_FFFF, 8'hFF);
        send_request(lls_pkg::OP_FIND, 32'hFFFF_FFFF, 8'h00);
        send_request(lls_pkg::OP_FIND_MIN, 32'hFFFF_FFFF, 8'hFF);
        send_request(lls_pkg::OP_SET, 32'h0, 8'hFF);
        send_request(lls_pkg::OP_FIND_MIN, 32'h0, 8'h00);
        send_request(lls_pkg::OP_SET, 32'hFFFF_FFFF, 8'h00);
        send_request(lls_pkg::OP_FIND_MIN, 32'h0, 8'h00);
        send_request(lls_pkg::OP_SET, 32'h0, 8'h00);
        send_request(lls_pkg::OP_FIND_MIN, 32'h0, 8'h00);
        send_request(lls_pkg::OP_DELETE, 32'h0, 8'h00);
        send_request(lls_pkg::OP_DELETE, 32'h0, 8'h00);
        send_request(lls_pkg::OP_FIND_MIN, 32'h0, 8'h00);
        send_request(lls_pkg::OP_DELETE, 32'hFFFF_FFFF, 8'h00);
        send_request(lls_pkg::OP_FIND_MIN, 32'h0, 8'h00);
    endtask

    task automatic test_full_table();
        for (int i = 0; i < lls_pkg::TABLE_ENTRIES + 6; i++) begin
            send_request(lls_pkg::OP_ADD, key_pool[i], 8'($urandom));
        end
        send_request(lls_pkg::OP_ADD, key_pool[3], 8'h00);
        send_request(lls_pkg::OP_FIND_MIN, 32'h0, 8'h00);
        send_request(lls_pkg::OP_SET, key_pool[lls_pkg::TABLE_ENTRIES - 1], 8'hFF);
        send_request(lls_pkg::OP_FIND, key_pool[lls_pkg::TABLE_ENTRIES - 1], 8'h00);
        for (int i = 0; i < lls_pkg::TABLE_ENTRIES; i += 2) begin
            send_request(lls_pkg::OP_DELETE, key_pool[i], 8'h00);
        end
        send_request(lls_pkg::OP_FIND_MIN, 32'h0, 8'h00);
    endtask

    task automatic test_backpressure();
        hold_seq++;
        repeat (6) send_random_request();
        wait_drained();
    endtask

    task automatic test_idle_traffic(input int count);
        tx_idle_pct = 18;
        rx_idle_pct = 18;
        repeat (count) send_random_request();
    endtask

    task automatic test_burst_traffic(input int count);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        repeat (count) send_random_request();
        tx_idle_pct = 18;
        rx_idle_pct = 18;
    endtask

    always @(posedge i_clk) begin
        if (hold_seen != hold_seq) begin
            hold_seen = hold_seq;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            i_stall <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99) < rx_idle_pct);
        end
    end

    always @(posedge i_clk) begin : result_checker
        t_session_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_results.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, expected none, actual found=%0b key=%h load=%h status=%0d",
                         $time, o_found, o_result_key, o_result_load, o_status);
            end else begin
                want = pending_results.pop_front();
                n_checked++;
                if (o_found !== want.found || o_result_key !== want.key ||
                    o_result_load !== want.load || o_status !== want.status) begin
                    errors++;
                    $display("%0t: mismatch, expected found=%0b key=%h load=%h status=%0d, actual found=%0b key=%h load=%h status=%0d",
                             $time, want.found, want.key, want.load, want.status,
                             o_found, o_result_key, o_result_load, o_status);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
                no_progress = 0;
            end else begin
                no_progress = no_progress + 1;
            end
            if (no_progress >= STALL_LIMIT) begin
                $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    initial begin
        for (int i = 0; i < lls_pkg::TABLE_ENTRIES; i++) begin
            tbl_valid[i] = 1'b0;
            tbl_key[i]   = '0;
            tbl_load[i]  = '0;
        end
        key_pool[0] = 32'h0000_0000;
        key_pool[1] = 32'hFFFF_FFFF;
        key_pool[2] = 32'h0000_0001;
        key_pool[3] = 32'h8000_0000;
        for (int i = 4; i < KEY_POOL_SIZE; i++) begin
            key_pool[i] = $urandom;
        end
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_ops();
        test_full_table();
        test_backpressure();
        test_idle_traffic(300);
        test_burst_traffic(150);
        test_idle_traffic(300);

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Covered %0d requests (all opcodes, full and duplicate adds, min ties, backpressure),",
                 n_sent);
        $display("checked %0d results: %0d full-table adds, %0d duplicate adds, %0d minimum hits",
                 n_checked, n_full_adds, n_dup_adds, n_min_hits);
        if (errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
